// File: src/ccd_pkg.sv
// Shared types and constants of the console command demultiplexer.
`default_nettype none

package ccd_pkg;

  // Character codes the command parser reacts to
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  // Reset values of the configuration registers
  localparam logic [7:0] PREFIX_RESET = 8'h21;
  localparam logic [7:0] LETTER_RESET = 8'h54;

  // Configuration register indexes
  localparam logic CFG_PREFIX = 1'b0;
  localparam logic CFG_LETTER = 1'b1;

  typedef enum logic [1:0] {
    KIND_PASS     = 2'd0,
    KIND_ECHO     = 2'd1,
    KIND_DISPATCH = 2'd2
  } kind_e;

  // Result slot currently presented on the output
  typedef enum logic [1:0] {
    SLOT_DISPATCH = 2'd0,
    SLOT_MAIN     = 2'd1,
    SLOT_LF       = 2'd2
  } slot_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [7:0]  command_letter;
    logic [3:0]  param_count;
    logic [63:0] param_bytes;
    logic        last;
  } out_t;

  // Everything the output sequencer needs to emit the results of one byte
  typedef struct packed {
    logic        has_dispatch;
    kind_e       main_kind;
    logic [7:0]  main_byte;
    logic        has_lf;
    logic [7:0]  letter;
    logic [3:0]  count;
    logic [63:0] params;
  } plan_t;

endpackage : ccd_pkg

`default_nettype wire

// File: src/ccd_parser.sv
// Command parser: mode, letter, parameter store and the result plan of each byte.
`default_nettype none

module ccd_parser import ccd_pkg::*; #(
  parameter int PARAM_BYTES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_t        in_data_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] prefix_i,
  input  wire logic [7:0] dispatch_i,
  output plan_t           plan_o
);

  localparam int IdxW = (PARAM_BYTES > 1) ? $clog2(PARAM_BYTES) : 1;

  logic            mode_q, mode_d;
  logic [7:0]      letter_q, letter_d;
  logic [3:0]      count_q, count_d;
  logic [7:0]      store_q [PARAM_BYTES];
  logic            store_we;
  logic [IdxW-1:0] store_idx;
  logic [7:0]      rx;
  logic            load;

  assign rx        = in_data_i.rx_byte;
  assign load      = accept_i && !in_data_i.framing_error && !in_data_i.overrun_error;
  assign store_idx = count_q[IdxW-1:0];

  always_comb begin
    mode_d   = mode_q;
    letter_d = letter_q;
    count_d  = count_q;
    store_we = 1'b0;

    plan_o              = '0;
    plan_o.main_kind    = KIND_ECHO;
    plan_o.main_byte    = rx;
    plan_o.letter       = letter_q;
    plan_o.count        = count_q;
    for (int i = 0; i < PARAM_BYTES; i++) begin
      plan_o.params[8*i +: 8] = store_q[i];
    end

    if (rx == prefix_i) begin
      mode_d = 1'b1;
    end else if (!mode_q) begin
      plan_o.main_kind = KIND_PASS;
    end else begin
      plan_o.has_lf = (rx == CH_CR);
      if (letter_q == CH_NUL) begin
        if (rx != CH_CR && rx != CH_LF) begin
          letter_d = rx;
        end
      end else if (rx == CH_CR) begin
        plan_o.has_dispatch = (letter_q == dispatch_i);
        letter_d            = CH_NUL;
        count_d             = '0;
      end else if (count_q < 4'(PARAM_BYTES)) begin
        store_we = 1'b1;
        count_d  = count_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      letter_q <= CH_NUL;
      count_q  <= '0;
    end else if (load) begin
      mode_q   <= mode_d;
      letter_q <= letter_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PARAM_BYTES; i++) begin
        store_q[i] <= '0;
      end
    end else if (load && store_we) begin
      store_q[store_idx] <= rx;
    end
  end

endmodule : ccd_parser

`default_nettype wire

// File: src/console_command_demux_top.sv
// Top level of the console command demultiplexer: config, parser and output sequencer.
// Usage
//   Input channel: one received byte per transfer with its framing and overrun
//   flags. A flagged byte is taken and dropped without any effect.
//   Output channel: one result per transfer (passthrough, echo or dispatch),
//   with last set on the final result of each input byte.
//   Config port: write command prefix (index 0) or dispatch letter (index 1)
//   whenever the block is idle; writes take effect at once.
// Timing
//   The first result of a byte is presented the cycle after its transfer.
//   A byte yields one to three results, one per output transfer, and holds
//   the result plan register until its final result leaves. A new byte is
//   taken in the same cycle as the final result of the previous one leaves,
//   so single-result bytes flow at one per cycle while ready stays high.
// Reset
//   Clears command mode, letter, parameter count and the parameter store,
//   and restores the default prefix and dispatch letter.
// Stalls
//   While the receiver holds ready low the current result is held and no
//   new byte is taken.
`default_nettype none

module console_command_demux_top import ccd_pkg::*; #(
  parameter int PARAM_BYTES = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  logic [7:0] prefix_q, letter_cfg_q;
  plan_t      plan, plan_q;
  logic       busy_q, busy_d;
  slot_e      slot_q, slot_d;
  logic       accept, load, advance, fin;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q     <= PREFIX_RESET;
      letter_cfg_q <= LETTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREFIX: prefix_q     <= cfg_data_i;
        CFG_LETTER: letter_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take a byte when the plan register is empty or drains this cycle
  assign accept     = in_valid_i && in_ready_o;
  assign load       = accept && !in_data_i.framing_error && !in_data_i.overrun_error;
  assign advance    = busy_q && out_ready_i;
  assign fin        = advance && out_data_o.last;
  assign in_ready_o = !busy_q || fin;

  ccd_parser #(
    .PARAM_BYTES(PARAM_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .accept_i   (accept),
    .prefix_i   (prefix_q),
    .dispatch_i (letter_cfg_q),
    .plan_o     (plan)
  );

  // Next slot
  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (load) begin
      busy_d = 1'b1;
      slot_d = plan.has_dispatch ? SLOT_DISPATCH : SLOT_MAIN;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (advance) begin
      case (slot_q)
        SLOT_DISPATCH: slot_d = SLOT_MAIN;
        SLOT_MAIN:     slot_d = SLOT_LF;
        default:       slot_d = slot_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SLOT_MAIN;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
    end
  end

  // Hold the plan of the byte being emitted
  always_ff @(posedge clk_i) begin
    if (load) begin
      plan_q <= plan;
    end
  end

  // Result fields of the current slot
  always_comb begin
    out_valid_o = busy_q;
    out_data_o  = '0;
    case (slot_q)
      SLOT_DISPATCH: begin
        out_data_o.kind           = KIND_DISPATCH;
        out_data_o.command_letter = plan_q.letter;
        out_data_o.param_count    = plan_q.count;
        out_data_o.param_bytes    = plan_q.params;
      end
      SLOT_MAIN: begin
        out_data_o.kind      = plan_q.main_kind;
        out_data_o.data_byte = plan_q.main_byte;
        out_data_o.last      = !plan_q.has_lf;
      end
      SLOT_LF: begin
        out_data_o.kind      = KIND_ECHO;
        out_data_o.data_byte = CH_LF;
        out_data_o.last      = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // A new byte may only enter while the final result of the previous one leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && in_ready_o |-> out_ready_i && out_data_o.last)
    else $error("input taken while results still pending");

  // The dispatch slot is only ever shown for a plan that carries a dispatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && slot_q == SLOT_DISPATCH |-> plan_q.has_dispatch)
    else $error("dispatch slot without dispatch");

  // The added LF only follows an echoed CR
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && slot_q == SLOT_LF |-> plan_q.main_byte == CH_CR && plan_q.has_lf)
    else $error("LF slot without CR");

  // A transfer that is not the final result leaves another result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("results of a byte lost");
`endif

endmodule : console_command_demux_top

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench of the console command demultiplexer with its own behavioural predictor.
`default_nettype none

module tb import ccd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARAM_BYTES = 8;
  // Generous ceiling: a few hundred bytes, at most three results each, long stalls on both sides
  localparam int CYCLE_LIMIT = 200000;
  // Cycles the block may still spend on a dropped byte once every result is out
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = CFG_PREFIX;
  logic [7:0]  cfg_data_i  = 8'h00;

  // Predictor state: configuration and parser, as the block should hold them
  logic [7:0]  prefix_cfg  = PREFIX_RESET;
  logic [7:0]  letter_cfg  = LETTER_RESET;
  logic        console_on  = 1'b0;
  logic [7:0]  open_letter = CH_NUL;
  logic [3:0]  param_fill  = '0;
  logic [7:0]  param_mem [PARAM_BYTES];

  out_t        pending_results [$];
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  int          bytes_taken     = 0;
  bit          no_gaps         = 1'b0;
  bit          hold_request    = 1'b0;

  console_command_demux_top #(
    .PARAM_BYTES(PARAM_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < PARAM_BYTES; i++) param_mem[i] = 8'h00;
  end

  function automatic out_t make_result(kind_e k, logic [7:0] data, logic [7:0] letter,
                                       logic [3:0] count, logic [63:0] params);
    out_t r;
    r.kind           = k;
    r.data_byte      = data;
    r.command_letter = letter;
    r.param_count    = count;
    r.param_bytes    = params;
    r.last           = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted byte and queue them, advancing the parser
  function automatic void predict_console_results(in_t item);
    out_t        res [3];
    int          n;
    logic [7:0]  b;
    logic [63:0] store;
    n = 0;
    b = item.rx_byte;
    // Drop flagged bytes outright: no result and no state change
    if (item.framing_error || item.overrun_error) return;
    if (b == prefix_cfg) begin
      // The prefix enters command mode for good and never reaches the parser
      console_on = 1'b1;
      res[n++] = make_result(KIND_ECHO, b, 8'h00, 4'd0, 64'd0);
    end else if (!console_on) begin
      res[n++] = make_result(KIND_PASS, b, 8'h00, 4'd0, 64'd0);
    end else begin
      if (open_letter == CH_NUL) begin
        // No command open: CR and LF never become the letter; zero leaves it empty anyway
        if (b != CH_CR && b != CH_LF) open_letter = b;
      end else if (b == CH_CR) begin
        if (open_letter == letter_cfg) begin
          for (int i = 0; i < PARAM_BYTES; i++) store[i*8 +: 8] = param_mem[i];
          res[n++] = make_result(KIND_DISPATCH, 8'h00, open_letter, param_fill, store);
        end
        open_letter = CH_NUL;
        param_fill  = '0;
      end else if (param_fill < PARAM_BYTES) begin
        // Store the parameter; surplus bytes fall through to the echo only
        param_mem[param_fill[2:0]] = b;
        param_fill = param_fill + 4'd1;
      end
      res[n++] = make_result(KIND_ECHO, b, 8'h00, 4'd0, 64'd0);
      if (b == CH_CR) res[n++] = make_result(KIND_ECHO, CH_LF, 8'h00, 4'd0, 64'd0);
    end
    res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  // Sender gap: mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one byte and hold it until the transfer; valid stays high into a
  // back-to-back transfer and is lowered only when a gap or a drain follows
  task automatic send_byte(input logic [7:0] b, input logic fe = 1'b0, input logic oe = 1'b0);
    int   gap;
    in_t  item;
    gap = pick_gap();
    item.rx_byte       = b;
    item.framing_error = fe;
    item.overrun_error = oe;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_console_results(item);
    if (!fe && !oe) bytes_taken++;
  endtask

  // Occasionally corrupt the byte with one or both receiver error flags
  task automatic send_maybe_flagged(input logic [7:0] b);
    logic [1:0] flags;
    flags = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : 2'b00;
    send_byte(b, flags[1], flags[0]);
  endtask

  // Drop valid, wait for every queued result, then let a dropped byte settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the prefix register, then the letter register; only called with the block idle
  task automatic write_config(input logic [7:0] prefix, input logic [7:0] letter);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PREFIX;
    cfg_data_i <= prefix;
    @(posedge clk_i);
    prefix_cfg = prefix;
    cfg_idx_i  <= CFG_LETTER;
    cfg_data_i <= letter;
    @(posedge clk_i);
    letter_cfg = letter;
    cfg_we_i   <= 1'b0;
  endtask

  // Before the prefix: bytes pass straight through, flagged prefixes change nothing
  task automatic test_passthrough();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(LETTER_RESET);
    send_byte(PREFIX_RESET, 1'b1, 1'b0);
    send_byte(PREFIX_RESET, 1'b0, 1'b1);
    drain_results();
  endtask

  // Walk the console through its corner cases under the reset configuration
  task automatic test_command_directed();
    send_byte(PREFIX_RESET);
    // Terminators and zero with no command open: echo only
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_NUL);
    // Matching command with one parameter more than the store holds
    send_byte(LETTER_RESET);
    for (int i = 0; i < PARAM_BYTES + 1; i++) send_byte(8'h31 + 8'(i));
    send_byte(CH_CR);
    // Letter that does not match: no dispatch, still clears
    send_byte(8'h58);
    send_byte(CH_CR);
    // Prefix inside a command is echoed and leaves the parse alone; stale bytes show
    send_byte(LETTER_RESET);
    send_byte(PREFIX_RESET);
    send_byte(8'h71);
    send_byte(CH_CR);
    drain_results();
  endtask

  // Mostly well-formed commands with random content, the rest noise
  task automatic run_random_commands(input int count);
    int          stop_at;
    int          nparams;
    logic [7:0]  letter;
    stop_at = bytes_taken + count;
    while (bytes_taken < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        letter  = ($urandom_range(0, 3) != 0) ? letter_cfg : 8'($urandom_range(0, 255));
        nparams = ($urandom_range(0, 9) < 8) ? $urandom_range(0, PARAM_BYTES)
                                             : $urandom_range(PARAM_BYTES + 1, PARAM_BYTES + 4);
        send_maybe_flagged(letter);
        for (int i = 0; i < nparams; i++) send_maybe_flagged(8'($urandom_range(0, 255)));
        send_maybe_flagged(CH_CR);
      end else begin
        case ($urandom_range(0, 5))
          0:       send_maybe_flagged(CH_CR);
          1:       send_maybe_flagged(CH_LF);
          2:       send_maybe_flagged(CH_NUL);
          3:       send_maybe_flagged(prefix_cfg);
          default: send_maybe_flagged(8'($urandom_range(0, 255)));
        endcase
      end
    end
    drain_results();
  endtask

  // Run random traffic under the current setting, then under others, extremes first
  task automatic test_random_settings();
    run_random_commands(50);
    write_config(8'h00, 8'hFF);
    run_random_commands(50);
    write_config(8'hFF, 8'h00);
    run_random_commands(40);
    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_random_commands(50);
    write_config(PREFIX_RESET, LETTER_RESET);
    no_gaps = 1'b1;
    run_random_commands(30);
    no_gaps = 1'b0;
    run_random_commands(30);
  endtask

  // Hold the receiver off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    send_byte(letter_cfg);
    for (int i = 0; i < 14; i++) send_byte(8'($urandom_range(0, 255)));
    send_byte(CH_CR);
    no_gaps      = 1'b0;
    drain_results();
  endtask

  // Receiver: random runs of ready and stall, plus one long counted hold-off on request
  initial begin
    int  run_left;
    int  hold_left;
    bit  level;
    run_left  = 0;
    hold_left = 0;
    level     = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          level = ($urandom_range(0, 99) < 65);
          if (level) run_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 8)
                                                         : $urandom_range(30, 80);
          else       run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
        end
        run_left--;
        out_ready_i <= level;
      end
    end
  end

  task automatic report_field(input string name, input logic [63:0] want, input logic [63:0] got);
    $display("%0t ns: mismatch in %s: expected %h, actual %h", $time, name, want, got);
    mismatch_count++;
  endtask

  // Check every output transfer against the oldest expectation; guard the run length
  always @(posedge clk_i) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end else if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.kind !== out_data_o.kind)
          report_field("kind", 64'(want.kind), 64'(out_data_o.kind));
        if (want.data_byte !== out_data_o.data_byte)
          report_field("data_byte", 64'(want.data_byte), 64'(out_data_o.data_byte));
        if (want.command_letter !== out_data_o.command_letter)
          report_field("command_letter", 64'(want.command_letter),
                       64'(out_data_o.command_letter));
        if (want.param_count !== out_data_o.param_count)
          report_field("param_count", 64'(want.param_count), 64'(out_data_o.param_count));
        if (want.param_bytes !== out_data_o.param_bytes)
          report_field("param_bytes", want.param_bytes, out_data_o.param_bytes);
        if (want.last !== out_data_o.last)
          report_field("last", 64'(want.last), 64'(out_data_o.last));
      end
    end
  end

  // Sequence the tests: reset once, then directed, random and backpressure phases
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough();
    test_command_directed();
    test_random_settings();
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule : tb

`default_nettype wire
